### src/tdl_pkg.sv
// Shared types and constants for the tanh drive distortion lowpass core.
// No dependencies; every other file in src imports this package.
package tdl_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int DRIVE_W       = 5;
   localparam int PCT_W         = 7;
   localparam int COEF_W        = 26;
   localparam int STATE_W       = 32;
   localparam int GAIN_W        = 12;
   localparam int CSR_IDX_W     = 3;
   localparam int ACC_W         = 64;
   localparam int MUL_B_W       = 26;
   localparam int MCNT_W        = $clog2(MUL_B_W);
   localparam int DIV_N_W       = 48;
   localparam int DIV_D_W       = 14;
   localparam int DCNT_W        = $clog2(DIV_N_W);
   localparam int FRAC_W        = 16;
   localparam int ARG_RANGE     = 8;
   localparam longint unsigned INV_E_Q32 = 64'd1580030169;

   localparam int CHANNEL_COUNT_DEF = 2;
   localparam int TANH_ENTRIES_DEF  = 256;

   localparam logic [CSR_IDX_W-1:0] REG_DRIVE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B0    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_A2    = 3'd5;

   localparam logic [DRIVE_W-1:0] DRIVE_RST = 5'd5;
   localparam logic [PCT_W-1:0]   MIX_RST   = 7'd50;
   localparam logic [PCT_W-1:0]   LEVEL_RST = 7'd80;
   localparam logic [COEF_W-1:0]  B0_RST    = 26'd2097152;
   localparam logic [COEF_W-1:0]  A1_RST    = 26'd0;
   localparam logic [COEF_W-1:0]  A2_RST    = 26'd1441792;
   localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;

   localparam logic [DIV_D_W-1:0] POS_DIV = 14'd10240;
   localparam logic [DIV_D_W-1:0] LVL_DIV = 14'd10000;

   typedef struct packed {
      logic               start;
      logic [ACC_W-1:0]   a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

### src/tdl_ser_mul.sv
// Bit-serial unsigned multiplier: one multiplier bit per cycle, shift and add.
// Depends on tdl_pkg.
module tdl_ser_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  tdl_pkg::mul_req_type        req,
   output tdl_pkg::unit_stat_type      stat,
   output logic [tdl_pkg::ACC_W-1:0]   product
);
   import tdl_pkg::*;

   logic [ACC_W-1:0]   a_ff, a_in, acc_ff, acc_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [MCNT_W-1:0]  cnt_ff, cnt_in;
   logic               run_ff, run_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in   = req.a;
         b_in   = req.b;
         acc_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MCNT_W'(MUL_B_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

### src/tdl_ser_div.sv
// Restoring unsigned divider: one quotient bit per cycle.
// Depends on tdl_pkg.
module tdl_ser_div (
   input  logic                          clock,
   input  logic                          reset,
   input  tdl_pkg::div_req_type          req,
   output tdl_pkg::unit_stat_type        stat,
   output logic [tdl_pkg::DIV_N_W-1:0]   quotient
);
   import tdl_pkg::*;

   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIV_D_W:0]   trial, diff;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic               run_ff, run_in, done_ff, done_in;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_N_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (req.start) begin
         quo_in = req.dividend;
         dvs_in = req.divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[DIV_D_W]) begin
            rem_in = diff[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_N_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

### src/tdl_tanh_lut.sv
// Constant tanh table in Q1.23, built at elaboration, with registered reads
// of an entry and its upper neighbor. Depends on tdl_pkg.
module tdl_tanh_lut #(
   parameter int TANH_TABLE_ENTRIES = tdl_pkg::TANH_ENTRIES_DEF,
   parameter int IDX_W              = $clog2(TANH_TABLE_ENTRIES + 1)
) (
   input  logic                           clock,
   input  logic [IDX_W-1:0]               idx,
   output logic [tdl_pkg::SAMPLE_W-1:0]   t_lo,
   output logic [tdl_pkg::SAMPLE_W-1:0]   t_hi
);
   import tdl_pkg::*;

   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q, r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         q = q << 1;
         if (r >= den) begin
            r    = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [SAMPLE_W-1:0] tanh_entry(input int unsigned i);
      longint unsigned u, k, f, term, e, num, den, j;
      longint          acc;
      int unsigned     n;
      u    = udiv64(((64'(i)) << 32) * 64'(2 * ARG_RANGE), 64'(TANH_TABLE_ENTRIES));
      k    = u >> 32;
      f    = u & 64'hFFFF_FFFF;
      acc  = 64'sh1_0000_0000;
      term = 64'h1_0000_0000;
      for (n = 1; n <= 24; n++) begin
         term = udiv64((term * f) >> 32, 64'(n));
         if (n[0]) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > 64'sh1_0000_0000) acc = 64'sh1_0000_0000;
      e = longint'(acc);
      for (j = 0; j < k; j++) e = (e * INV_E_Q32) >> 32;
      num = (64'h1_0000_0000 - e) << 23;
      den = 64'h1_0000_0000 + e;
      return SAMPLE_W'(udiv64(num + (den >> 1), den));
   endfunction

   logic [SAMPLE_W-1:0] tab [TANH_TABLE_ENTRIES+1];
   logic [IDX_W-1:0]    idx_up;

   for (genvar gi = 0; gi <= TANH_TABLE_ENTRIES; gi++) begin : g_tab
      localparam logic [SAMPLE_W-1:0] ENTRY = tanh_entry(gi);
      assign tab[gi] = ENTRY;
   end

   assign idx_up = (idx == IDX_W'(TANH_TABLE_ENTRIES)) ? idx : idx + 1'b1;

   always_ff @(posedge clock) begin
      t_lo <= tab[idx];
      t_hi <= tab[idx_up];
   end

endmodule

### src/tanh_drive_distortion_lowpass_core.sv
// Soft-clip distortion and per-channel lowpass: tanh drive, dry/wet mix, level, biquad.
// Depends on tdl_pkg, tdl_ser_mul, tdl_ser_div and tdl_tanh_lut.
//
// One sample is in flight at a time: req_stall stays high from acceptance until the
// result is loaded into the output register. Each item takes nine products in the
// bit-serial multiplier (26 steps each) and two quotients in the restoring divider (48
// steps each), plus unit handoff, table read, rounding and state update. A finished
// result waits in its own register, so the next item is accepted while rsp_valid is
// still stalled. csr_ready is always high; write registers only while no item is in
// flight.
module tanh_drive_distortion_lowpass_core #(
   parameter int CHANNEL_COUNT      = tdl_pkg::CHANNEL_COUNT_DEF,
   parameter int TANH_TABLE_ENTRIES = tdl_pkg::TANH_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tdl_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic                                 req_channel_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tdl_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                 rsp_channel_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tdl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tdl_pkg::COEF_W-1:0]           csr_data
);
   import tdl_pkg::*;

   localparam int IDX_W = $clog2(TANH_TABLE_ENTRIES + 1);
   localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_GAIN   = 5'd1;
   localparam logic [4:0] ST_SCALE  = 5'd2;
   localparam logic [4:0] ST_POS    = 5'd3;
   localparam logic [4:0] ST_LUT    = 5'd4;
   localparam logic [4:0] ST_INTERP = 5'd5;
   localparam logic [4:0] ST_FRAC   = 5'd6;
   localparam logic [4:0] ST_DRYW   = 5'd7;
   localparam logic [4:0] ST_WETW   = 5'd8;
   localparam logic [4:0] ST_LVL    = 5'd9;
   localparam logic [4:0] ST_LVLDIV = 5'd10;
   localparam logic [4:0] ST_B0W    = 5'd11;
   localparam logic [4:0] ST_YSUM   = 5'd12;
   localparam logic [4:0] ST_YRND   = 5'd13;
   localparam logic [4:0] ST_A1     = 5'd14;
   localparam logic [4:0] ST_A1W    = 5'd15;
   localparam logic [4:0] ST_A2W    = 5'd16;
   localparam logic [4:0] ST_UPD    = 5'd17;
   localparam logic [4:0] ST_OUT    = 5'd18;

   function automatic logic signed [ACC_W-1:0] round23(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-1:0] m;
      logic [ACC_W-1:0] r;
      m = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
      r = (m + ACC_W'(64'd4194304)) >> 23;
      return x[ACC_W-1] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return 32'sh8000_0000;
      return STATE_W'(x);
   endfunction

   // configuration
   logic [DRIVE_W-1:0]       drive_ff;
   logic [PCT_W-1:0]         mix_ff, level_ff;
   logic signed [COEF_W-1:0] b0_ff, a1_ff, a2_ff;

   // sequencer
   logic [4:0]               state_ff, state_in;
   logic signed [SAMPLE_W-1:0] dry_ff, dry_in;
   logic                     neg_ff, neg_in, ch_ff, ch_in, pneg_ff, pneg_in;
   logic [CH_W-1:0]          chsel_ff, chsel_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic [SAMPLE_W-1:0]      y_ff, y_in;
   logic [ACC_W-1:0]         macc_ff, macc_in;
   logic signed [ACC_W-1:0]  p_ff, p_in, q_ff, q_in, yf_ff, yf_in;
   logic signed [ACC_W-1:0]  sum1_ff, sum1_in, sum2_ff, sum2_in;
   logic signed [STATE_W-1:0] s1_ff [CHANNEL_COUNT];
   logic signed [STATE_W-1:0] s2_ff [CHANNEL_COUNT];
   logic                     st_wr;
   logic                     rsp_valid_ff, rsp_valid_in, rsp_ch_ff, rsp_ch_in;
   logic signed [SAMPLE_W-1:0] rsp_smp_ff, rsp_smp_in;

   logic [SAMPLE_W-1:0]      dry_mag;
   logic [GAIN_W-1:0]        gain;
   logic [PCT_W-1:0]         m_cl, o_cl;
   logic [MUL_B_W-1:0]       b0_mag, a1_mag, a2_mag;
   logic [ACC_W-1:0]         yf_mag;
   logic [ACC_W-1:0]         sgn_prod;
   logic signed [ACC_W-1:0]  s1_ext, s2_ext;
   logic                     out_free, accept;
   logic [SAMPLE_W-1:0]      t_lo, t_hi;

   mul_req_type              mreq;
   div_req_type              dreq;
   unit_stat_type            mstat, dstat;
   logic [ACC_W-1:0]         mprod;
   logic [DIV_N_W-1:0]       dquo;

   tdl_ser_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mreq),
      .stat    (mstat),
      .product (mprod)
   );

   tdl_ser_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (dreq),
      .stat     (dstat),
      .quotient (dquo)
   );

   tdl_tanh_lut #(
      .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES),
      .IDX_W              (IDX_W)
   ) u_lut (
      .clock (clock),
      .idx   (idx_ff),
      .t_lo  (t_lo),
      .t_hi  (t_hi)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= DRIVE_RST;
         mix_ff   <= MIX_RST;
         level_ff <= LEVEL_RST;
         b0_ff    <= B0_RST;
         a1_ff    <= A1_RST;
         a2_ff    <= A2_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DRIVE: drive_ff <= csr_data[DRIVE_W-1:0];
            REG_MIX:   mix_ff   <= csr_data[PCT_W-1:0];
            REG_LEVEL: level_ff <= csr_data[PCT_W-1:0];
            REG_B0:    b0_ff    <= csr_data;
            REG_A1:    a1_ff    <= csr_data;
            REG_A2:    a2_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign gain    = GAIN_W'(12'd30 * GAIN_W'(drive_ff))
                  + GAIN_W'(12'd3 * GAIN_W'(drive_ff) * GAIN_W'(drive_ff));
   assign m_cl    = (mix_ff > PCT_FULL) ? PCT_FULL : mix_ff;
   assign o_cl    = (level_ff > PCT_FULL) ? PCT_FULL : level_ff;
   assign dry_mag = dry_ff[SAMPLE_W-1] ? SAMPLE_W'(-dry_ff) : SAMPLE_W'(dry_ff);
   assign b0_mag  = b0_ff[COEF_W-1] ? MUL_B_W'(-b0_ff) : MUL_B_W'(b0_ff);
   assign a1_mag  = a1_ff[COEF_W-1] ? MUL_B_W'(-a1_ff) : MUL_B_W'(a1_ff);
   assign a2_mag  = a2_ff[COEF_W-1] ? MUL_B_W'(-a2_ff) : MUL_B_W'(a2_ff);
   assign yf_mag  = yf_ff[ACC_W-1] ? ACC_W'(-yf_ff) : ACC_W'(yf_ff);
   assign sgn_prod = ACC_W'(-mprod);
   assign s1_ext  = ACC_W'(s1_ff[chsel_ff]) <<< 23;
   assign s2_ext  = ACC_W'(s2_ff[chsel_ff]) <<< 23;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      dry_in    = dry_ff;
      neg_in    = neg_ff;
      ch_in     = ch_ff;
      chsel_in  = chsel_ff;
      pneg_in   = pneg_ff;
      idx_in    = idx_ff;
      frac_in   = frac_ff;
      y_in      = y_ff;
      macc_in   = macc_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      yf_in     = yf_ff;
      sum1_in   = sum1_ff;
      sum2_in   = sum2_ff;
      st_wr     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ch_in    = rsp_ch_ff;
      rsp_smp_in   = rsp_smp_ff;
      mreq      = '0;
      dreq      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dry_in   = req_sample_in;
               neg_in   = req_sample_in[SAMPLE_W-1];
               ch_in    = req_channel_index;
               chsel_in = (32'(req_channel_index) < CHANNEL_COUNT) ?
                          CH_W'(req_channel_index) : CH_W'(CHANNEL_COUNT - 1);
               state_in = ST_GAIN;
               mreq.start = 1'b1;
               mreq.a     = ACC_W'($unsigned(req_sample_in[SAMPLE_W-1] ?
                            -req_sample_in : req_sample_in));
               mreq.b     = MUL_B_W'(gain);
            end
         end
         ST_GAIN: begin
            if (mstat.done) begin
               mreq.start = 1'b1;
               mreq.a     = mprod;
               mreq.b     = MUL_B_W'(TANH_TABLE_ENTRIES);
               state_in   = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mstat.done) begin
               dreq.start    = 1'b1;
               dreq.dividend = DIV_N_W'(mprod);
               dreq.divisor  = POS_DIV;
               state_in      = ST_POS;
            end
         end
         ST_POS: begin
            if (dstat.done) begin
               if (dquo[DIV_N_W-1:FRAC_W] >= 32'(TANH_TABLE_ENTRIES)) begin
                  idx_in  = IDX_W'(TANH_TABLE_ENTRIES);
                  frac_in = '0;
               end else begin
                  idx_in  = IDX_W'(dquo[DIV_N_W-1:FRAC_W]);
                  frac_in = dquo[FRAC_W-1:0];
               end
               state_in = ST_LUT;
            end
         end
         ST_LUT: begin
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            mreq.start = 1'b1;
            mreq.a     = ACC_W'(t_hi - t_lo);
            mreq.b     = MUL_B_W'(frac_ff);
            state_in   = ST_FRAC;
         end
         ST_FRAC: begin
            if (mstat.done) begin
               y_in       = t_lo + SAMPLE_W'(mprod >> FRAC_W);
               mreq.start = 1'b1;
               mreq.a     = ACC_W'(dry_mag);
               mreq.b     = MUL_B_W'(PCT_FULL - m_cl);
               state_in   = ST_DRYW;
            end
         end
         ST_DRYW: begin
            if (mstat.done) begin
               macc_in    = mprod;
               mreq.start = 1'b1;
               mreq.a     = ACC_W'(y_ff);
               mreq.b     = MUL_B_W'(m_cl);
               state_in   = ST_WETW;
            end
         end
         ST_WETW: begin
            if (mstat.done) begin
               mreq.start = 1'b1;
               mreq.a     = macc_ff + mprod;
               mreq.b     = MUL_B_W'(o_cl);
               state_in   = ST_LVL;
            end
         end
         ST_LVL: begin
            if (mstat.done) begin
               dreq.start    = 1'b1;
               dreq.dividend = DIV_N_W'(mprod);
               dreq.divisor  = LVL_DIV;
               state_in      = ST_LVLDIV;
            end
         end
         ST_LVLDIV: begin
            if (dstat.done) begin
               mreq.start = 1'b1;
               mreq.a     = ACC_W'(dquo[SAMPLE_W-1:0]);
               mreq.b     = b0_mag;
               pneg_in    = neg_ff ^ b0_ff[COEF_W-1];
               state_in   = ST_B0W;
            end
         end
         ST_B0W: begin
            if (mstat.done) begin
               p_in     = pneg_ff ? $signed(sgn_prod) : $signed(mprod);
               state_in = ST_YSUM;
            end
         end
         ST_YSUM: begin
            sum1_in  = p_ff + s1_ext;
            state_in = ST_YRND;
         end
         ST_YRND: begin
            yf_in    = round23(sum1_ff);
            state_in = ST_A1;
         end
         ST_A1: begin
            mreq.start = 1'b1;
            mreq.a     = yf_mag;
            mreq.b     = a1_mag;
            state_in   = ST_A1W;
         end
         ST_A1W: begin
            if (mstat.done) begin
               q_in       = (yf_ff[ACC_W-1] ^ a1_ff[COEF_W-1]) ?
                            $signed(sgn_prod) : $signed(mprod);
               mreq.start = 1'b1;
               mreq.a     = yf_mag;
               mreq.b     = a2_mag;
               state_in   = ST_A2W;
            end
         end
         ST_A2W: begin
            if (mstat.done) begin
               sum1_in  = (p_ff <<< 1) - q_ff + s2_ext;
               sum2_in  = p_ff - ((yf_ff[ACC_W-1] ^ a2_ff[COEF_W-1]) ?
                          $signed(sgn_prod) : $signed(mprod));
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            st_wr    = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               if (yf_ff > 64'sd8388607) rsp_smp_in = 24'sh7FFFFF;
               else if (yf_ff < -64'sd8388608) rsp_smp_in = 24'sh800000;
               else rsp_smp_in = SAMPLE_W'(yf_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chsel_ff     <= '0;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            s1_ff[c] <= '0;
            s2_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chsel_ff     <= chsel_in;
         if (st_wr) begin
            s1_ff[chsel_ff] <= sat32(round23(sum1_ff));
            s2_ff[chsel_ff] <= sat32(round23(sum2_ff));
         end
      end
      dry_ff     <= dry_in;
      neg_ff     <= neg_in;
      ch_ff      <= ch_in;
      pneg_ff    <= pneg_in;
      idx_ff     <= idx_in;
      frac_ff    <= frac_in;
      y_ff       <= y_in;
      macc_ff    <= macc_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      yf_ff      <= yf_in;
      sum1_ff    <= sum1_in;
      sum2_ff    <= sum2_in;
      rsp_ch_ff  <= rsp_ch_in;
      rsp_smp_ff <= rsp_smp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_smp_ff;
   assign rsp_channel_out = rsp_ch_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_GAIN))
      else $error("accepted item did not start the gain product");

   a_idle_units: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!mstat.busy && !dstat.busy))
      else $error("arithmetic unit running while idle");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      dstat.done |-> (state_ff == ST_POS || state_ff == ST_LVLDIV))
      else $error("quotient arrived outside a divide wait");

   a_chsel_range: assert property (@(posedge clock) disable iff (reset)
      32'(chsel_ff) < CHANNEL_COUNT)
      else $error("filter state index out of range");

endmodule
